>>> src/acs_pkg.sv
// Package: AES-128 tables, round functions and the queued item type.
`default_nettype none
package acs_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;
    localparam int COUNT_W = 5;
    localparam int ROUNDS  = 10;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 5'd16;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [1:0] REG_IV_LOW   = 2'd3;

    typedef struct packed {
        logic [BLOCK_W-1:0] ctr;
        logic [BLOCK_W-1:0] data;
        logic [COUNT_W-1:0] count;
    } acs_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [11] = '{
        8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] v, input int i);
        return v[BLOCK_W-1-8*i -: 8];
    endfunction

    function automatic logic [BLOCK_W-1:0] next_round_key(input logic [BLOCK_W-1:0] rk,
                                                          input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        t = {SBOX[get_byte(rk, 13)] ^ rc, SBOX[get_byte(rk, 14)],
             SBOX[get_byte(rk, 15)], SBOX[get_byte(rk, 12)]};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey
    function automatic logic [BLOCK_W-1:0] aes_round(input logic [BLOCK_W-1:0] s,
                                                     input logic [BLOCK_W-1:0] rk,
                                                     input logic last);
        logic [7:0] t [16];
        logic [BLOCK_W-1:0] m;
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[c*4+i] = SBOX[get_byte(s, ((c + i) & 3) * 4 + i)];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[c*4];
            a1 = t[c*4+1];
            a2 = t[c*4+2];
            a3 = t[c*4+3];
            if (last)
            begin
                m[BLOCK_W-1-32*c -: 32] = {a0, a1, a2, a3};
            end
            else
            begin
                m[BLOCK_W-1-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                                           a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                                           a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                                           xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
            end
        end
        return m ^ rk;
    endfunction

endpackage
`default_nettype wire

>>> src/acs_in_if.sv
// Input channel: one data block with its start mark and byte count.
`default_nettype none
interface acs_in_if;
    logic        valid;
    logic        ready;
    logic        start_message;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;

    modport source (output valid, start_message, data_high, data_low, byte_count,
                    input ready);
    modport sink   (input valid, start_message, data_high, data_low, byte_count,
                    output ready);
endinterface
`default_nettype wire

>>> src/acs_out_if.sv
// Output channel: one processed block with its byte count.
`default_nettype none
interface acs_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  out_count;

    modport source (output valid, out_high, out_low, out_count, input ready);
    modport sink   (input valid, out_high, out_low, out_count, output ready);
endinterface
`default_nettype wire

>>> src/aes128_ctr_stream_cipher.sv
// Top level: AES-128 counter-mode stream cipher with config registers.
// From input transfer to result valid: queue, initial key add, nine
// registered round stages, last round folded into the result register;
// the whole pipeline holds while the output stalls.
// Throughput: one block per cycle (pipelined rounds) unless output stalls.
// Reset: key, IV and counter clear to zero; queue and pipeline empty.
`default_nettype none
module aes128_ctr_stream_cipher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    acs_in_if.sink           in_ch,
    acs_out_if.source        out_ch
);
    import acs_pkg::*;

    // configuration registers
    logic [HALF_W-1:0] key_high_reg;
    logic [HALF_W-1:0] key_low_reg;
    logic [HALF_W-1:0] iv_high_reg;
    logic [HALF_W-1:0] iv_low_reg;

    logic      q_full;
    logic      q_not_empty;
    logic      q_pop;
    logic      push;
    acs_item_t front_item;
    acs_item_t q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                REG_IV_LOW:   iv_low_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // input transfer whenever the queue has room
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    // front: picks counter (IV on start of message), saturates the count
    acs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .start_message (in_ch.start_message),
        .data_high     (in_ch.data_high),
        .data_low      (in_ch.data_low),
        .byte_count    (in_ch.byte_count),
        .iv            ({iv_high_reg, iv_low_reg}),
        .item          (front_item)
    );

    // decouples input stalls from the cipher pipeline
    acs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: keystream generation, XOR, masking, result register
    acs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .key         ({key_high_reg, key_low_reg}),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_ch      (out_ch)
    );
endmodule
`default_nettype wire

>>> src/acs_front.sv
// Front end: counter tracking, count saturation, item build.
`default_nettype none
module acs_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic                     start_message,
    input  wire logic [63:0]              data_high,
    input  wire logic [63:0]              data_low,
    input  wire logic [4:0]               byte_count,
    input  wire logic [127:0]             iv,
    output acs_pkg::acs_item_t            item
);
    import acs_pkg::*;

    logic [BLOCK_W-1:0] ctr_reg;
    logic [BLOCK_W-1:0] ctr_next;
    logic [BLOCK_W-1:0] ctr_use;

    assign ctr_use  = start_message ? iv : ctr_reg;
    assign ctr_next = push ? ctr_use + 128'd1 : ctr_reg;

    always_comb
    begin
        item.ctr   = ctr_use;
        item.data  = {data_high, data_low};
        item.count = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctr_reg <= '0;
        else
            ctr_reg <= ctr_next;
    end
endmodule
`default_nettype wire

>>> src/acs_queue.sv
// Short FIFO between front and back ends.
`default_nettype none
module acs_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  acs_pkg::acs_item_t      push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output acs_pkg::acs_item_t      head
);
    import acs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    acs_item_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [PTR_W:0]      fill_reg;
    logic [PTR_W:0]      fill_next;

    assign full      = (fill_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        fill_next = fill_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end
endmodule
`default_nettype wire

>>> src/acs_back.sv
// Back end: pipelined AES-128 with on-the-fly key schedule, XOR and byte mask.
`default_nettype none
module acs_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [127:0]       key,
    input  wire logic               q_not_empty,
    input  acs_pkg::acs_item_t      q_head,
    output logic                    q_pop,
    acs_out_if.source               out_ch
);
    import acs_pkg::*;

    logic               adv;
    logic               vld_reg   [ROUNDS];
    logic [BLOCK_W-1:0] st_reg    [ROUNDS];
    logic [BLOCK_W-1:0] rk_reg    [ROUNDS];
    logic [BLOCK_W-1:0] dat_reg   [ROUNDS];
    logic [COUNT_W-1:0] cnt_reg   [ROUNDS];
    logic [BLOCK_W-1:0] rk_next   [1:ROUNDS];
    logic [BLOCK_W-1:0] st_next   [1:ROUNDS];
    logic [BLOCK_W-1:0] res_next;
    logic               out_vld_reg;
    logic [BLOCK_W-1:0] out_dat_reg;
    logic [COUNT_W-1:0] out_cnt_reg;

    // whole pipeline moves together whenever the output slot frees up
    assign adv   = !out_vld_reg || out_ch.ready;
    assign q_pop = adv && q_not_empty;

    always_comb
    begin
        for (int r = 1; r <= ROUNDS; r++)
        begin
            rk_next[r] = next_round_key(rk_reg[r-1], RCON[r]);
            st_next[r] = aes_round(st_reg[r-1], rk_next[r], r == ROUNDS);
        end
        for (int i = 0; i < 16; i++)
        begin
            res_next[BLOCK_W-1-8*i -: 8] = (COUNT_W'(i) < cnt_reg[ROUNDS-1])
                ? get_byte(st_next[ROUNDS], i) ^ get_byte(dat_reg[ROUNDS-1], i) : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROUNDS; r++)
                vld_reg[r] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= q_not_empty;
            for (int r = 1; r < ROUNDS; r++)
                vld_reg[r] <= vld_reg[r-1];
            out_vld_reg <= vld_reg[ROUNDS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0]  <= q_head.ctr ^ key;
            rk_reg[0]  <= key;
            dat_reg[0] <= q_head.data;
            cnt_reg[0] <= q_head.count;
            for (int r = 1; r < ROUNDS; r++)
            begin
                st_reg[r]  <= st_next[r];
                rk_reg[r]  <= rk_next[r];
                dat_reg[r] <= dat_reg[r-1];
                cnt_reg[r] <= cnt_reg[r-1];
            end
            out_dat_reg <= res_next;
            out_cnt_reg <= cnt_reg[ROUNDS-1];
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.out_high  = out_dat_reg[BLOCK_W-1:HALF_W];
    assign out_ch.out_low   = out_dat_reg[HALF_W-1:0];
    assign out_ch.out_count = out_cnt_reg;
endmodule
`default_nettype wire

>>> sim/tb_aes128_ctr_stream_cipher.sv
// Testbench for the AES-128 counter-mode stream cipher: random stimulus, self-checking.
`timescale 1ns / 1ps
module tb_aes128_ctr_stream_cipher;
    import acs_pkg::*;

    typedef struct {
        bit          start;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  cnt;
    } block_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  cnt;
    } cipher_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    acs_in_if  in_ch ();
    acs_out_if out_ch ();

    aes128_ctr_stream_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow copies of the block's registers and message counter
    logic [127:0] key_shadow;
    logic [127:0] iv_shadow;
    logic [127:0] ctr_shadow;

    block_t  blocks_pending[$];
    cipher_t cipher_expected[$];
    block_t  block_on_bus;
    int      send_gap;
    int      recv_stall;
    bit      calm;          // no idling on either side while set
    int      errors;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous cap on the whole run
    initial
    begin
        #20ms;
        $display("tb_aes128_ctr_stream_cipher: done, errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encryption of one counter block; byte i at bits [127-8i -: 8]
    function automatic logic [127:0] keystream_block(input logic [127:0] key,
                                                     input logic [127:0] ctr);
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   rk [16];
        logic [7:0]   tw [4];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
        begin
            rk[i] = key[127-8*i -: 8];
            st[i] = ctr[127-8*i -: 8] ^ rk[i];
        end
        for (int r = 1; r <= 10; r++)
        begin
            // substitute and shift rows, state is column-major
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    sh[c*4+i] = SBOX[st[((c + i) % 4) * 4 + i]];
            for (int c = 0; c < 4; c++)
            begin
                a0 = sh[c*4];
                a1 = sh[c*4+1];
                a2 = sh[c*4+2];
                a3 = sh[c*4+3];
                if (r == 10)
                begin
                    st[c*4] = a0; st[c*4+1] = a1; st[c*4+2] = a2; st[c*4+3] = a3;
                end
                else
                begin
                    st[c*4]   = gf_double(a0 ^ a1) ^ a1 ^ a2 ^ a3;
                    st[c*4+1] = gf_double(a1 ^ a2) ^ a0 ^ a2 ^ a3;
                    st[c*4+2] = gf_double(a2 ^ a3) ^ a0 ^ a1 ^ a3;
                    st[c*4+3] = gf_double(a0 ^ a3) ^ a0 ^ a1 ^ a2;
                end
            end
            // next round key, words updated in order
            tw[0] = SBOX[rk[13]] ^ RCON[r];
            tw[1] = SBOX[rk[14]];
            tw[2] = SBOX[rk[15]];
            tw[3] = SBOX[rk[12]];
            for (int j = 0; j < 4; j++)
                rk[j] = rk[j] ^ tw[j];
            for (int w = 1; w < 4; w++)
                for (int j = 0; j < 4; j++)
                    rk[w*4+j] = rk[w*4+j] ^ rk[(w-1)*4+j];
            for (int i = 0; i < 16; i++)
                st[i] = st[i] ^ rk[i];
        end
        for (int i = 0; i < 16; i++)
            res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    // Work out the processed block for one transfer and advance the counter
    function automatic cipher_t cipher_block(input block_t b);
        cipher_t      c;
        logic [127:0] ks;
        logic [127:0] txt;
        logic [4:0]   n;
        n = (b.cnt > FULL_COUNT) ? FULL_COUNT : b.cnt;
        if (b.start)
            ctr_shadow = iv_shadow;
        ks = keystream_block(key_shadow, ctr_shadow);
        txt = {b.hi, b.lo} ^ ks;
        for (int i = 0; i < 16; i++)
            if (i >= n)
                txt[127-8*i -: 8] = 8'h00;
        ctr_shadow = ctr_shadow + 128'd1;
        c.hi = txt[127:64];
        c.lo = txt[63:0];
        c.cnt = n;
        return c;
    endfunction

    function automatic int draw_wait();
        if (calm)
            return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    endfunction

    // Input driver: one transfer per accepted block, random gap between blocks
    always @(posedge clk)
    begin
        bit busy;
        busy = 1'b0;
        if (rst_n)
        begin
            busy = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                cipher_expected = {cipher_expected, cipher_block(block_on_bus)};
                busy = 1'b0;
                send_gap = draw_wait();
            end
            if (!busy)
            begin
                if (send_gap > 0 || blocks_pending.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    block_on_bus = blocks_pending.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.start_message <= block_on_bus.start;
                    in_ch.data_high     <= block_on_bus.hi;
                    in_ch.data_low      <= block_on_bus.lo;
                    in_ch.byte_count    <= block_on_bus.cnt;
                end
            end
        end
    end

    // Output monitor: random stalls on ready, each transfer checked in order
    always @(posedge clk)
    begin
        cipher_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (cipher_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no block outstanding", $realtime);
                end
                else
                begin
                    want = cipher_expected.pop_front();
                    if (out_ch.out_high !== want.hi)
                        report_mismatch("out_high", out_ch.out_high, want.hi);
                    if (out_ch.out_low !== want.lo)
                        report_mismatch("out_low", out_ch.out_low, want.lo);
                    if (out_ch.out_count !== want.cnt)
                        report_mismatch("out_count", 64'(out_ch.out_count), 64'(want.cnt));
                end
                recv_stall = draw_wait();
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic add_block(input bit start, input logic [63:0] hi, input logic [63:0] lo,
                             input logic [4:0] cnt);
        block_t b;
        b.start = start;
        b.hi = hi;
        b.lo = lo;
        b.cnt = cnt;
        blocks_pending = {blocks_pending, b};
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Registers are only written here, with the pipeline drained
    task automatic load_config(input logic [127:0] key, input logic [127:0] iv);
        logic [63:0] vals [4];
        logic [1:0]  idx [4];
        vals = '{key[127:64], key[63:0], iv[127:64], iv[63:0]};
        idx  = '{REG_KEY_HIGH, REG_KEY_LOW, REG_IV_HIGH, REG_IV_LOW};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        key_shadow = key;
        iv_shadow  = iv;
    endtask

    // Sender holds off until every outstanding result is back, then the tail
    task automatic drain();
        int guard;
        guard = 0;
        while (blocks_pending.size() != 0 || in_ch.valid || cipher_expected.size() != 0)
            @(posedge clk);
        while (guard < 30)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // Random messages: mostly well formed, some noise blocks
    task automatic queue_messages(input int total);
        int n;
        int len;
        n = 0;
        while (n < total)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_block($urandom_range(0, 1), rand64(), rand64(), 5'($urandom_range(0, 31)));
                n++;
            end
            else
            begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    add_block(i == 0, rand64(), rand64(),
                              (i == len - 1) ? 5'($urandom_range(1, 16)) : FULL_COUNT);
                n += len;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.start_message = 1'b0;
        in_ch.data_high = '0;
        in_ch.data_low = '0;
        in_ch.byte_count = '0;
        out_ch.ready = 1'b0;
        key_shadow = '0;
        iv_shadow = '0;
        ctr_shadow = '0;
        send_gap = 0;
        recv_stall = 0;
        calm = 1'b0;
        errors = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset config; first block carries no start mark so the zero counter is used
        add_block(1'b0, '0, '0, FULL_COUNT);
        add_block(1'b0, '1, '1, FULL_COUNT);
        add_block(1'b0, '1, '1, 5'd0);        // nothing valid, counter still moves
        add_block(1'b0, '1, '1, 5'd1);
        add_block(1'b0, '1, '1, 5'd15);
        add_block(1'b0, '1, '1, 5'd17);       // saturates to a full block
        add_block(1'b0, rand64(), rand64(), 5'd31);
        add_block(1'b1, '0, '0, 5'd8);
        add_block(1'b0, rand64(), rand64(), 5'd7);   // short block mid message
        add_block(1'b0, rand64(), rand64(), FULL_COUNT);
        drain();

        // All-ones key and IV: counter wraps through zero
        load_config('1, '1);
        calm = 1'b1;
        add_block(1'b1, '0, '0, FULL_COUNT);
        add_block(1'b0, '0, '0, FULL_COUNT);
        add_block(1'b0, '1, '0, 5'd9);
        add_block(1'b1, rand64(), rand64(), 5'd16);
        drain();

        // Carry from the low half into the high half
        load_config({rand64(), rand64()}, {rand64(), 64'hffff_ffff_ffff_fffe});
        calm = 1'b0;
        for (int i = 0; i < 4; i++)
            add_block(i == 0, rand64(), rand64(), FULL_COUNT);
        add_block(1'b1, rand64(), rand64(), 5'd2);
        drain();

        for (int p = 0; p < 5; p++)
        begin
            load_config({rand64(), rand64()}, {rand64(), rand64()});
            calm = (p == 2);
            queue_messages(110);
            drain();
        end

        load_config('0, '0);
        calm = 1'b0;
        queue_messages(20);
        drain();

        if (errors == 0)
            $display("tb_aes128_ctr_stream_cipher: done, clean");
        else
            $display("tb_aes128_ctr_stream_cipher: done, errors");
        $finish;
    end

endmodule

>>> sim.f
src/acs_pkg.sv
src/acs_in_if.sv
src/acs_out_if.sv
src/acs_front.sv
src/acs_queue.sv
src/acs_back.sv
src/aes128_ctr_stream_cipher.sv
sim/tb_aes128_ctr_stream_cipher.sv
